// ===== design/dlsc_pkg.sv =====
// Shared types and constants for the diagonal Latin square checker.
`default_nettype none

package dlsc_pkg;

    localparam int ORDER_W = 4;
    localparam int COORD_W = 4;
    localparam int SYM_W   = 4;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int COUNT_W = 10;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd10;
    localparam logic [COUNT_W-1:0] COUNT_SAT   = 10'd1023;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    typedef struct packed {
        logic               last_cell;
        logic [SYM_W-1:0]   symbol;
        logic [COORD_W-1:0] col_index;
        logic [COORD_W-1:0] row_index;
    } t_cell;

    typedef struct packed {
        logic diagonal_ok;
        logic latin_ok;
    } t_result;

endpackage

`default_nettype wire

// ===== design/diagonal_latin_square_checker_top.sv =====
// Top level of the diagonal Latin square checker: stream ports, order register, pipeline.
`default_nettype none

// Cells of one square arrive on the slave stream in row-major order, one cell
// per transaction, the final cell flagged by s_axis_tlast. Each cell is taken
// into an input register, checked from there against per-row, per-column and
// diagonal symbol bitmaps, and on the final cell one result transaction
// carries latin_ok and diagonal_ok; the bitmaps are then cleared for the
// next square. One cell is taken every cycle except while a last cell waits
// on a full output register; other cells keep flowing while a result is held.
// The bitmap test-and-set for a cell completes while the cell sits in its
// input register, and the next cell reads the bitmaps that cell just wrote.
// A last cell passes through the input register, and its result through the
// result register, to the master stream. Write the order only while no
// square is in flight; a value of zero or above MAX_ORDER fails every square.
module diagonal_latin_square_checker_top #(
    parameter int MAX_ORDER = 10
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration: order of the square
    input  wire                                 i_cfg_we,
    input  wire [dlsc_pkg::ORDER_W-1:0]         i_cfg_wdata,
    // cell stream
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // [3:0] row_index, [7:4] col_index, [11:8] symbol, [15:12] zero
    input  wire [dlsc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  wire                                 s_axis_tlast,   // last_cell
    // result stream
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [0] latin_ok, [1] diagonal_ok, [7:2] zero
    output logic [dlsc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    logic [dlsc_pkg::ORDER_W-1:0] r_order;

    // input register
    logic              r_in_valid;
    dlsc_pkg::t_cell   r_in_cell;

    // result register
    logic              r_out_valid;
    dlsc_pkg::t_result r_out;

    dlsc_pkg::t_result core_result;
    logic              adv;
    logic              out_free;

    // a last cell needs a free result slot; other cells always advance
    assign out_free      = !r_out_valid || m_axis_tready;
    assign adv           = r_in_valid && (!r_in_cell.last_cell || out_free);
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= dlsc_pkg::ORDER_RESET;
        end else if (i_cfg_we) begin
            r_order <= i_cfg_wdata;
        end
    end

    // hold the cell until the check stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cell.row_index <= s_axis_tdata[3:0];
            r_in_cell.col_index <= s_axis_tdata[7:4];
            r_in_cell.symbol    <= s_axis_tdata[11:8];
            r_in_cell.last_cell <= s_axis_tlast;
        end
    end

    dlsc_core #(
        .MAX_ORDER (MAX_ORDER)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_order  (r_order),
        .i_adv    (adv),
        .i_cell   (r_in_cell),
        .o_result (core_result)
    );

    // load a result on a last cell, drop it once the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_cell.last_cell) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_cell.last_cell) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(dlsc_pkg::OUT_TDATA_W-2){1'b0}},
                            r_out.diagonal_ok, r_out.latin_ok};

endmodule

`default_nettype wire

// ===== design/dlsc_core.sv =====
// Bitmap state and per-cell checks of the diagonal Latin square checker.
`default_nettype none

module dlsc_core #(
    parameter int MAX_ORDER = 10
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire [dlsc_pkg::ORDER_W-1:0]  i_order,
    input  wire                          i_adv,
    input  wire dlsc_pkg::t_cell         i_cell,
    output dlsc_pkg::t_result            o_result
);

    localparam int IDX_W = $clog2(MAX_ORDER);
    localparam int MAXC_W = dlsc_pkg::ORDER_W + 1;
    localparam logic [MAXC_W-1:0] MAX_ORDER_C = MAXC_W'(MAX_ORDER);

    logic [MAX_ORDER-1:0] r_row_seen [MAX_ORDER];
    logic [MAX_ORDER-1:0] r_col_seen [MAX_ORDER];
    logic [MAX_ORDER-1:0] r_diag_seen;
    logic [MAX_ORDER-1:0] r_anti_seen;
    logic                 r_latin_fail;
    logic                 r_diag_fail;
    logic [dlsc_pkg::COUNT_W-1:0] r_count;

    logic                           n_latin_fail;
    logic                           n_diag_fail;
    logic [dlsc_pkg::COUNT_W-1:0]   n_count;

    logic [dlsc_pkg::PROD_W-1:0]    nn;
    logic [dlsc_pkg::PROD_W-1:0]    rn;
    logic [dlsc_pkg::PROD_W:0]      pos;
    logic                           order_bad;
    logic                           pos_ok;
    logic                           take;
    logic [IDX_W-1:0]               ri;
    logic [IDX_W-1:0]               ci;
    logic [IDX_W-1:0]               si;
    logic [MAX_ORDER-1:0]           sym_bit;
    logic                           on_diag;
    logic                           on_anti;
    logic                           row_dup;
    logic                           col_dup;
    logic                           diag_dup;
    logic                           anti_dup;
    logic                           latin_bad;

    always_comb begin
        order_bad = (i_order == '0) || ({1'b0, i_order} > MAX_ORDER_C);
        nn  = {{dlsc_pkg::ORDER_W{1'b0}}, i_order} * {{dlsc_pkg::ORDER_W{1'b0}}, i_order};
        rn  = {{dlsc_pkg::ORDER_W{1'b0}}, i_cell.row_index}
            * {{dlsc_pkg::ORDER_W{1'b0}}, i_order};
        pos = {1'b0, rn} + {{(dlsc_pkg::PROD_W+1-dlsc_pkg::COORD_W){1'b0}}, i_cell.col_index};
        // row*order + col equals the count exactly when (row, col) is the
        // next row-major position, given col < order and count < order^2
        pos_ok = (r_count < dlsc_pkg::COUNT_W'(nn))
              && (i_cell.col_index < i_order)
              && (dlsc_pkg::COUNT_W'(pos) == r_count);
        take = !order_bad && pos_ok && (i_cell.symbol < i_order);

        ri = i_cell.row_index[IDX_W-1:0];
        ci = i_cell.col_index[IDX_W-1:0];
        si = i_cell.symbol[IDX_W-1:0];
        sym_bit = {{(MAX_ORDER-1){1'b0}}, 1'b1} << si;

        on_diag = (i_cell.row_index == i_cell.col_index);
        on_anti = ({1'b0, i_cell.row_index} + {1'b0, i_cell.col_index})
               == ({1'b0, i_order} - 5'd1);

        row_dup  = take && ((r_row_seen[ri] & sym_bit) != '0);
        col_dup  = take && ((r_col_seen[ci] & sym_bit) != '0);
        diag_dup = take && on_diag && ((r_diag_seen & sym_bit) != '0);
        anti_dup = take && on_anti && ((r_anti_seen & sym_bit) != '0);

        n_latin_fail = r_latin_fail || !take || row_dup || col_dup;
        n_diag_fail  = r_diag_fail || diag_dup || anti_dup;
        n_count      = (r_count == dlsc_pkg::COUNT_SAT) ? r_count
                                                        : r_count + dlsc_pkg::COUNT_W'(1);

        latin_bad = n_latin_fail || order_bad || (n_count != dlsc_pkg::COUNT_W'(nn));
        o_result.latin_ok    = !latin_bad;
        o_result.diagonal_ok = !latin_bad && !n_diag_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && i_cell.last_cell)) begin
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_row_seen[k] <= '0;
                r_col_seen[k] <= '0;
            end
            r_diag_seen  <= '0;
            r_anti_seen  <= '0;
            r_latin_fail <= 1'b0;
            r_diag_fail  <= 1'b0;
            r_count      <= '0;
        end else if (i_adv) begin
            if (take) begin
                r_row_seen[ri] <= r_row_seen[ri] | sym_bit;
                r_col_seen[ci] <= r_col_seen[ci] | sym_bit;
                if (on_diag) begin
                    r_diag_seen <= r_diag_seen | sym_bit;
                end
                if (on_anti) begin
                    r_anti_seen <= r_anti_seen | sym_bit;
                end
            end
            r_latin_fail <= n_latin_fail;
            r_diag_fail  <= n_diag_fail;
            r_count      <= n_count;
        end
    end

endmodule

`default_nettype wire
